// ===== design/bpa_pkg.sv =====
package bpa_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_ROOT,
        ST_IDLE,
        ST_A_FIND,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_PAGE_WR,
        ST_F_RD,
        ST_F_CHK,
        ST_MERGE_RD,
        ST_MERGE_CHK,
        ST_SET_WR,
        ST_DONE
    } state_t;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Configuration register indexes.
    localparam int          CFG_IDX_W          = 2;
    localparam logic [1:0]  CFG_POOL_ORDER     = 2'd0;
    localparam logic [1:0]  CFG_POOL_BASE_PAGE = 2'd1;

    // Bits in one word of the free-bit tree memory.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Width of an order field; a 15-bit page count can ask for up to order 15.
    localparam int ORD_W = 5;

    // Result of the word scan unit.
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bitpos;
    } scan_t;

endpackage

// ===== design/bpa_ram.sv =====
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bpa_word_scan.sv =====
module bpa_word_scan #(
    parameter int NW  = 20,
    parameter int TAW = 10
) (
    input  logic [31:0]      word,
    input  logic [TAW-1:0]   word_addr,
    input  logic [NW-1:0]    lo,
    input  logic [NW-1:0]    hi,
    output bpa_pkg::scan_t   res
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] live;
    logic [NW-1:0]        node [0:WORD_BITS-1];

    // A bit counts only if its tree node lies inside the order being searched.
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            node[i] = NW'({word_addr, BIT_W'(i)});
            live[i] = word[i] && (node[i] >= lo) && (node[i] < hi);
        end
    end

    always_comb
    begin
        res.hit    = 1'b0;
        res.bitpos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (live[i])
            begin
                res.hit    = 1'b1;
                res.bitpos = BIT_W'(i);
            end
        end
    end

endmodule

// ===== design/buddy_page_allocator.sv =====
// Binary buddy page allocator over a pool of 2^P pages, P = min(pool_order,
// MAX_ORDER), starting at physical page pool_base_page.
// Command channel: a word (command, page_count, page_number) is taken at a
// rising edge with start high and busy low. busy stays high until the result
// word has been shown. The result (status, block_page, block_order,
// free_count) is on its ports for exactly one cycle with done high; the
// receiver cannot stall it, so it must take the word in that cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
// Index 0 is pool_order, index 1 is pool_base_page; other indexes are ignored.
// A write to a real register re-initializes the pool exactly as reset does.
// cfg_ready is low while a command runs or is being taken.
// After reset or such a write the block runs a clearing pass over its page
// memory and tree memory, then a step that marks the whole pool free; busy
// is high during that pass and no command is taken.
// An allocate picks an order, scans its tree words, splits level by level and
// writes the page entry; a refused one stops after picking the order. A free
// reads and checks the page entry, merges level by level, then sets a tree bit;
// a bad free stops after the read or the check. One command runs at a time; the
// next word can be taken in the cycle after done. Each split or merge
// level is one tree read and write; per-order free counts pick the order at once.
module buddy_page_allocator #(
    parameter int MAX_ORDER = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [14:0]                     page_count,
    input  logic [31:0]                     page_number,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [31:0]                     block_page,
    output logic [3:0]                      block_order,
    output logic [14:0]                     free_count
);
    import bpa_pkg::*;

    localparam int PAGES      = 1 << MAX_ORDER;
    localparam int TREE_WORDS = ((2 << MAX_ORDER) + WORD_BITS - 1) / WORD_BITS;
    localparam int TAW        = (TREE_WORDS > 1) ? $clog2(TREE_WORDS) : 1;
    localparam int PAW        = MAX_ORDER;
    localparam int NW         = MAX_ORDER + 6;
    localparam int OW         = $clog2(MAX_ORDER + 1);
    localparam int TW         = MAX_ORDER + 2;
    localparam int CW         = MAX_ORDER + 1;

    // Tree node index of block at page offset off and order ord.
    function automatic logic [NW-1:0] node_at(input logic [ORD_W-1:0] ord,
                                              input logic [PAW-1:0] off);
        logic [NW-1:0] first;
        first = (NW'(1) << (MAX_ORDER - 32'(ord))) - NW'(1);
        return first + (NW'(off) >> ord);
    endfunction

    state_t state_reg, state_next;

    logic [3:0]        pool_order_reg;
    logic [31:0]       pool_base_reg;
    logic [PAW-1:0]    clr_reg, clr_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [CW-1:0]     cnt_reg [0:MAX_ORDER];

    logic [14:0]       count_reg, count_next;
    logic [31:0]       pn_reg, pn_next;
    logic [ORD_W-1:0]  k_reg, k_next;
    logic [ORD_W-1:0]  j_reg, j_next;
    logic [PAW-1:0]    off_reg, off_next;
    logic [TAW-1:0]    word_reg, word_next;
    logic [NW-1:0]     tnode_reg, tnode_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       page_reg, page_next;
    logic [3:0]        order_reg, order_next;

    // Per-order free-block count update.
    logic              cnt_en, cnt_inc, cnt_init;
    logic [ORD_W-1:0]  cnt_ord;

    // Memory ports.
    logic              t_we;
    logic [TAW-1:0]    t_waddr, t_raddr;
    logic [31:0]       t_wdata, t_rdata;
    logic              p_we;
    logic [PAW-1:0]    p_waddr, p_raddr;
    logic [OW:0]       p_wdata, p_rdata;

    logic              accept, cfg_wr;
    logic [ORD_W-1:0]  p_eff, k_calc, j_sel, ko;
    logic              j_found, no_fit, in_range;
    logic [14:0]       cm1;
    logic [MAX_ORDER:0] avail;
    logic [NW-1:0]     lo, hi, hit_node, root_node, node_tmp;
    logic [31:0]       f_off, bit_mask;
    logic [PAW-1:0]    hit_off;
    scan_t             scan;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = ((state_reg == ST_IDLE) && !start) || (state_reg == ST_CLEAR)
                       || (state_reg == ST_ROOT);
    assign cfg_wr    = cfg_valid && cfg_ready
                       && ((cfg_index == CFG_POOL_ORDER) || (cfg_index == CFG_POOL_BASE_PAGE));

    assign p_eff = (32'(pool_order_reg) > MAX_ORDER) ? ORD_W'(MAX_ORDER)
                                                     : ORD_W'(pool_order_reg);

    // Round the requested count up to a power of two.
    assign cm1 = (count_reg == 15'd0) ? 15'd0 : count_reg - 15'd1;
    always_comb
    begin
        k_calc = '0;
        for (int i = 0; i < 15; i++)
        begin
            if (cm1[i])
            begin
                k_calc = ORD_W'(i + 1);
            end
        end
    end
    assign no_fit = k_calc > p_eff;

    // Smallest order at or above the request that holds a free block.
    always_comb
    begin
        j_sel   = '0;
        j_found = 1'b0;
        for (int i = MAX_ORDER; i >= 0; i--)
        begin
            avail[i] = (cnt_reg[i] != '0);
            if (avail[i] && (ORD_W'(i) >= k_calc) && (ORD_W'(i) <= p_eff))
            begin
                j_sel   = ORD_W'(i);
                j_found = 1'b1;
            end
        end
    end

    assign lo        = node_at(j_reg, '0);
    assign hi        = {lo[NW-2:0], 1'b1};
    assign hit_node  = NW'({word_reg, scan.bitpos});
    assign hit_off   = PAW'((hit_node - lo) << j_reg);
    assign root_node = node_at(p_eff, '0);
    assign f_off     = pn_reg - pool_base_reg;
    assign in_range  = f_off < (32'd1 << p_eff);
    assign bit_mask  = 32'd1 << tnode_reg[BIT_W-1:0];
    assign ko        = (ORD_W'(p_rdata[OW-1:0]) > p_eff) ? p_eff
                                                          : ORD_W'(p_rdata[OW-1:0]);

    bpa_word_scan #(
        .NW  (NW),
        .TAW (TAW)
    ) u_scan (
        .word      (t_rdata),
        .word_addr (word_reg),
        .lo        (lo),
        .hi        (hi),
        .res       (scan)
    );

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TREE_WORDS)
    ) u_tree_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // Each page entry holds the allocated mark and the block order.
    bpa_ram #(
        .WIDTH (OW + 1),
        .DEPTH (PAGES)
    ) u_page_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == PAW'(PAGES - 1))
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:      state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (command == CMD_ALLOC) ? ST_A_FIND : ST_F_RD;
                end
            end
            ST_A_FIND:    state_next = (no_fit || !j_found) ? ST_DONE : ST_SCAN_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:  state_next = scan.hit ? ST_SPLIT_RD : ST_SCAN_RD;
            ST_SPLIT_RD:  state_next = (j_reg > k_reg) ? ST_SPLIT_WR : ST_PAGE_WR;
            ST_SPLIT_WR:  state_next = ST_SPLIT_RD;
            ST_PAGE_WR:   state_next = ST_DONE;
            ST_F_RD:      state_next = in_range ? ST_F_CHK : ST_DONE;
            ST_F_CHK:     state_next = p_rdata[OW] ? ST_MERGE_RD : ST_DONE;
            ST_MERGE_RD:  state_next = (k_reg < p_eff) ? ST_MERGE_CHK : ST_SET_WR;
            ST_MERGE_CHK: state_next = t_rdata[tnode_reg[BIT_W-1:0]] ? ST_MERGE_RD
                                                                       : ST_SET_WR;
            ST_SET_WR:    state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
        if (cfg_wr)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Datapath and memory controls.
    always_comb
    begin
        clr_next    = clr_reg;
        total_next  = total_reg;
        count_next  = count_reg;
        pn_next     = pn_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        off_next    = off_reg;
        word_next   = word_reg;
        tnode_next  = tnode_reg;
        status_next = status_reg;
        page_next   = page_reg;
        order_next  = order_reg;
        cnt_en      = 1'b0;
        cnt_inc     = 1'b0;
        cnt_ord     = '0;
        cnt_init    = 1'b0;
        t_we        = 1'b0;
        t_waddr     = tnode_reg[TAW+BIT_W-1:BIT_W];
        t_wdata     = t_rdata | bit_mask;
        t_raddr     = word_reg;
        p_we        = 1'b0;
        p_waddr     = off_reg;
        p_wdata     = '0;
        p_raddr     = off_reg;
        node_tmp    = '0;
        done        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                p_we     = 1'b1;
                p_waddr  = clr_reg;
                p_wdata  = '0;
                t_we     = (32'(clr_reg) < TREE_WORDS);
                t_waddr  = clr_reg[TAW-1:0];
                t_wdata  = '0;
                clr_next = clr_reg + PAW'(1);
            end
            ST_ROOT:
            begin
                t_we       = 1'b1;
                t_waddr    = root_node[TAW+BIT_W-1:BIT_W];
                t_wdata    = 32'd1 << root_node[BIT_W-1:0];
                cnt_init   = 1'b1;
                total_next = TW'(1) << p_eff;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = page_count;
                    pn_next    = page_number;
                end
            end
            ST_A_FIND:
            begin
                status_next = STATUS_NO_SPACE;
                page_next   = '0;
                order_next  = '0;
                j_next      = j_sel;
                k_next      = k_calc;
                node_tmp    = node_at(j_sel, '0);
                word_next   = node_tmp[TAW+BIT_W-1:BIT_W];
            end
            ST_SCAN_RD:
            begin
                t_raddr = word_reg;
            end
            ST_SCAN_CHK:
            begin
                if (scan.hit)
                begin
                    t_we     = 1'b1;
                    t_waddr  = word_reg;
                    t_wdata  = t_rdata & ~(32'd1 << scan.bitpos);
                    cnt_en   = 1'b1;
                    cnt_ord  = j_reg;
                    off_next = hit_off;
                end
                else
                begin
                    word_next = word_reg + TAW'(1);
                end
            end
            ST_SPLIT_RD:
            begin
                if (j_reg > k_reg)
                begin
                    j_next     = j_reg - ORD_W'(1);
                    node_tmp   = node_at(j_next, off_reg | (PAW'(1) << j_next));
                    tnode_next = node_tmp;
                    t_raddr    = node_tmp[TAW+BIT_W-1:BIT_W];
                end
            end
            ST_SPLIT_WR:
            begin
                t_we    = 1'b1;
                t_wdata = t_rdata | bit_mask;
                cnt_en  = 1'b1;
                cnt_inc = 1'b1;
                cnt_ord = j_reg;
            end
            ST_PAGE_WR:
            begin
                p_we        = 1'b1;
                p_waddr     = off_reg;
                p_wdata     = {1'b1, OW'(k_reg)};
                total_next  = total_reg - (TW'(1) << k_reg);
                status_next = STATUS_OK;
                page_next   = pool_base_reg + 32'(off_reg);
                order_next  = 4'(k_reg);
            end
            ST_F_RD:
            begin
                status_next = STATUS_BAD_FREE;
                page_next   = pn_reg;
                order_next  = '0;
                off_next    = f_off[PAW-1:0];
                p_raddr     = f_off[PAW-1:0];
            end
            ST_F_CHK:
            begin
                if (p_rdata[OW])
                begin
                    p_we        = 1'b1;
                    p_waddr     = off_reg;
                    p_wdata     = '0;
                    total_next  = total_reg + (TW'(1) << ko);
                    k_next      = ko;
                    status_next = STATUS_OK;
                    order_next  = 4'(ko);
                end
            end
            ST_MERGE_RD:
            begin
                if (k_reg < p_eff)
                begin
                    node_tmp = node_at(k_reg, off_reg ^ (PAW'(1) << k_reg));
                end
                else
                begin
                    node_tmp = node_at(k_reg, off_reg);
                end
                tnode_next = node_tmp;
                t_raddr    = node_tmp[TAW+BIT_W-1:BIT_W];
            end
            ST_MERGE_CHK:
            begin
                if (t_rdata[tnode_reg[BIT_W-1:0]])
                begin
                    // Buddy is free at this order: absorb it and go one up.
                    t_we     = 1'b1;
                    t_wdata  = t_rdata & ~bit_mask;
                    cnt_en   = 1'b1;
                    cnt_ord  = k_reg;
                    off_next = off_reg & ~(PAW'(1) << k_reg);
                    k_next   = k_reg + ORD_W'(1);
                end
                else
                begin
                    node_tmp   = node_at(k_reg, off_reg);
                    tnode_next = node_tmp;
                    t_raddr    = node_tmp[TAW+BIT_W-1:BIT_W];
                end
            end
            ST_SET_WR:
            begin
                t_we    = 1'b1;
                t_wdata = t_rdata | bit_mask;
                cnt_en  = 1'b1;
                cnt_inc = 1'b1;
                cnt_ord = k_reg;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
        if (cfg_wr)
        begin
            clr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            pool_order_reg <= 4'd14;
            pool_base_reg  <= '0;
            clr_reg        <= '0;
            total_reg      <= '0;
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            if (cfg_valid && cfg_ready && (cfg_index == CFG_POOL_ORDER))
            begin
                pool_order_reg <= cfg_data[3:0];
            end
            if (cfg_valid && cfg_ready && (cfg_index == CFG_POOL_BASE_PAGE))
            begin
                pool_base_reg <= cfg_data;
            end
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                if (cnt_init)
                begin
                    cnt_reg[i] <= (ORD_W'(i) == p_eff) ? CW'(1) : '0;
                end
                else if (cnt_en && (cnt_ord == ORD_W'(i)))
                begin
                    cnt_reg[i] <= cnt_inc ? cnt_reg[i] + CW'(1) : cnt_reg[i] - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        pn_reg     <= pn_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        off_reg    <= off_next;
        word_reg   <= word_next;
        tnode_reg  <= tnode_next;
        status_reg <= status_next;
        page_reg   <= page_next;
        order_reg  <= order_next;
    end

    assign status      = status_reg;
    assign block_page  = page_reg;
    assign block_order = order_reg;
    assign free_count  = (32'(total_reg) > 32'd32767) ? 15'h7FFF : 15'(total_reg);

endmodule

// ===== design/bpa_checker.sv =====
module bpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [31:0] block_page,
    input logic [3:0]  block_order
);
    import bpa_pkg::*;

    // A result word only appears while a command is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // Results last exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not hold busy");

    // A failed allocate reports no block.
    a_no_space: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_NO_SPACE)) |-> (block_page == 32'd0 && block_order == 4'd0))
        else $error("no-space result carries a block");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

// ===== test/buddy_page_allocator_tb.sv =====
// Testbench for the buddy page allocator. Commands go in through the
// start/busy port, and results are taken from the done strobe. A scoreboard
// object keeps its own copy of the free tree, the allocation marks and the
// free-page total. It predicts each result when its command word is accepted
// and checks the results in order. The run goes through several pool
// settings. Each setting gets a directed or random mix of allocates, valid
// frees and bad frees.
module buddy_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int TREE_MAX    = 14;
    localparam int TREE_NODES  = (2 << TREE_MAX) - 1;
    localparam int POOL_PAGES  = 1 << TREE_MAX;
    // The limit must cover the whole clearing pass, in which no word moves.
    localparam int STALL_LIMIT = 60000;
    localparam int ITEMS       = 1400;
    // Writes to this index must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] block_page;
        logic [3:0]  block_order;
        logic [14:0] free_count;
    } alloc_result_t;

    // Holds the allocator state and the queue of results still owed.
    class alloc_scoreboard;
        bit            tree_free[TREE_NODES];
        bit            page_taken[POOL_PAGES];
        logic [3:0]    page_order[POOL_PAGES];
        int unsigned   pages_free;
        logic [3:0]    order_reg;
        logic [31:0]   base_reg;
        alloc_result_t owed[$];
        int            mismatches;

        function int pool_log2();
            return (order_reg > TREE_MAX) ? TREE_MAX : int'(order_reg);
        endfunction

        function int node(int k, int off);
            return ((1 << (TREE_MAX - k)) - 1) + (off >> k);
        endfunction

        function void clear_pool();
            foreach (tree_free[i]) tree_free[i] = 0;
            foreach (page_taken[i])
            begin
                page_taken[i] = 0;
                page_order[i] = '0;
            end
            tree_free[node(pool_log2(), 0)] = 1;
            pages_free = 1 << pool_log2();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_POOL_ORDER)
            begin
                order_reg = data[3:0];
                clear_pool();
            end
            else if (idx == CFG_POOL_BASE_PAGE)
            begin
                base_reg = data;
                clear_pool();
            end
        endfunction

        function void hard_reset();
            order_reg  = 4'd14;
            base_reg   = '0;
            mismatches = 0;
            owed.delete();
            clear_pool();
        endfunction

        function alloc_result_t make(logic [1:0] st, logic [31:0] pg, int ord);
            alloc_result_t r;
            r.status      = st;
            r.block_page  = pg;
            r.block_order = ord[3:0];
            r.free_count  = (pages_free > 32767) ? 15'h7fff : pages_free[14:0];
            return r;
        endfunction

        // Works out the result of one accepted command word and queues it.
        function alloc_result_t note_command(logic cmd, logic [14:0] count,
                                             logic [31:0] page);
            int p, k, j, off, ko, bud;
            bit hit;
            alloc_result_t r;
            p = pool_log2();
            if (cmd == CMD_ALLOC)
            begin
                k = 0;
                hit = 0;
                off = 0;
                while (k < 16 && (1 << k) < ((count == 0) ? 1 : int'(count)))
                    k++;
                if (k <= p)
                begin
                    for (j = k; j <= p && !hit; j++)
                        for (int b = 0; b < (1 << (p - j)) && !hit; b++)
                            if (tree_free[node(j, b << j)])
                            begin
                                off = b << j;
                                hit = 1;
                            end
                    j--;
                end
                if (!hit)
                    r = make(STATUS_NO_SPACE, '0, 0);
                else
                begin
                    tree_free[node(j, off)] = 0;
                    while (j > k)
                    begin
                        j--;
                        tree_free[node(j, off + (1 << j))] = 1;
                    end
                    page_taken[off] = 1;
                    page_order[off] = k[3:0];
                    pages_free -= 1 << k;
                    r = make(STATUS_OK, base_reg + off, k);
                end
            end
            else
            begin
                logic [31:0] rel;
                rel = page - base_reg;
                if (rel >= (32'd1 << p) || !page_taken[rel[13:0]])
                    r = make(STATUS_BAD_FREE, page, 0);
                else
                begin
                    off = int'(rel);
                    ko = (page_order[off] > p) ? p : int'(page_order[off]);
                    k = ko;
                    page_taken[off] = 0;
                    page_order[off] = '0;
                    pages_free += 1 << ko;
                    // Merge upward while the buddy at this order is free.
                    while (k < p)
                    begin
                        bud = off ^ (1 << k);
                        if (!tree_free[node(k, bud)])
                            break;
                        tree_free[node(k, bud)] = 0;
                        off &= ~(1 << k);
                        k++;
                    end
                    tree_free[node(k, off)] = 1;
                    r = make(STATUS_OK, page, ko);
                end
            end
            owed.push_back(r);
            return r;
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word with none expected: st=%0d pg=%h ord=%0d fc=%0d",
                             got.status, got.block_page, got.block_order, got.free_count);
                return;
            end
            exp = owed.pop_front();
            if (got.status !== exp.status || got.block_page !== exp.block_page ||
                got.block_order !== exp.block_order || got.free_count !== exp.free_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp st=%0d pg=%h ord=%0d fc=%0d, got st=%0d pg=%h ord=%0d fc=%0d",
                             exp.status, exp.block_page, exp.block_order, exp.free_count,
                             got.status, got.block_page, got.block_order, got.free_count);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 command = CMD_ALLOC;
    logic [14:0]          page_count = '0;
    logic [31:0]          page_number = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_ORDER;
    logic [31:0]          cfg_data = '0;
    logic                 done;
    logic [1:0]           status;
    logic [31:0]          block_page;
    logic [3:0]           block_order;
    logic [14:0]          free_count;

    alloc_scoreboard sb = new();
    // Start pages of blocks that the predictor says are allocated now.
    logic [31:0] live_blocks[$];
    int          stall_cycles = 0;

    always #2 clk = ~clk;

    buddy_page_allocator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .page_count(page_count), .page_number(page_number),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .status(status),
        .block_page(block_page), .block_order(block_order),
        .free_count(free_count)
    );

    // Result monitor: the done strobe lasts one cycle and cannot be stalled.
    always @(posedge clk)
    begin
        alloc_result_t got;
        if (rst_n && done)
        begin
            got.status      = status;
            got.block_page  = block_page;
            got.block_order = block_order;
            got.free_count  = free_count;
            sb.check_result(got);
        end
    end

    // Watchdog: counts cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drives one command word after a random gap and waits for it to be taken.
    // The live block list is kept in step with the prediction.
    task automatic send_command(logic cmd, logic [14:0] count, logic [31:0] page);
        int gap;
        alloc_result_t pred;
        gap = $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        command     <= cmd;
        page_count  <= count;
        page_number <= page;
        do @(posedge clk); while (busy);
        pred = sb.note_command(cmd, count, page);
        if (pred.status == STATUS_OK)
        begin
            if (cmd == CMD_ALLOC)
                live_blocks.push_back(pred.block_page);
            else
                foreach (live_blocks[i])
                    if (live_blocks[i] == page)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
        end
    endtask

    task automatic lower_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Lowers start and waits until every result is in.
    task automatic drain();
        lower_start();
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        live_blocks.delete();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random command word. Most words are well-formed allocates of a
    // fitting size or frees of live blocks. The rest are bad frees and
    // oversized requests.
    task automatic random_command();
        int sel, ord, p;
        logic [14:0] cnt;
        logic [31:0] pg;
        p = sb.pool_log2();
        sel = $urandom_range(0, 99);
        if (live_blocks.size() == 0 || sel < 48)
        begin
            ord = $urandom_range(0, p);
            if ($urandom_range(0, 19) == 0)
                cnt = 15'($urandom_range(0, 32767));
            else
                cnt = 15'($urandom_range((1 << ord) / 2 + 1, 1 << ord));
            send_command(CMD_ALLOC, cnt, 32'($urandom));
        end
        else if (sel < 88)
        begin
            pg = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_command(CMD_FREE, 15'($urandom), pg);
        end
        else if (sel < 94)
            send_command(CMD_FREE, 15'($urandom), $urandom);
        else
        begin
            // Near misses: inside the pool but usually not a block start.
            pg = sb.base_reg + $urandom_range(0, (1 << p) - 1);
            send_command(CMD_FREE, 15'($urandom), pg);
        end
    endtask

    initial
    begin
        int per_phase;
        logic [3:0]  orders[7];
        sb.hard_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset pool of 2^14 pages at base zero.
        send_command(CMD_ALLOC, 15'd16384, '0);
        send_command(CMD_ALLOC, 15'd1, '0);
        send_command(CMD_FREE, '0, 32'd0);
        send_command(CMD_FREE, '0, 32'd0);
        send_command(CMD_ALLOC, 15'd0, '1);
        send_command(CMD_ALLOC, 15'h7fff, '0);
        send_command(CMD_ALLOC, 15'd3, '0);
        send_command(CMD_ALLOC, 15'd8192, '0);
        send_command(CMD_ALLOC, 15'd8192, '0);
        send_command(CMD_FREE, '1, 32'd5);
        send_command(CMD_FREE, '0, 32'hffff_ffff);
        send_command(CMD_FREE, '0, 32'd16384);
        send_command(CMD_FREE, '0, 32'd4);
        send_command(CMD_FREE, '0, 32'd0);
        send_command(CMD_FREE, '0, 32'd0);
        send_command(CMD_ALLOC, 15'd16384, '0);

        // A write to an unused index must leave the pool as it is.
        write_cfg(CFG_UNUSED, 32'h0000_0003);
        send_command(CMD_ALLOC, 15'd2, '0);

        // Pool orders, including the smallest and one above the maximum.
        orders = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd9, 4'd5, 4'd14};
        per_phase = ITEMS / 7;
        foreach (orders[ph])
        begin
            write_cfg(CFG_POOL_ORDER, {28'($urandom_range(0, 32'h0fff_ffff)), orders[ph]});
            case (ph)
                0: write_cfg(CFG_POOL_BASE_PAGE, 32'hffff_0000);
                1: write_cfg(CFG_POOL_BASE_PAGE, 32'h0000_0000);
                default: write_cfg(CFG_POOL_BASE_PAGE, $urandom & 32'hffff_0000);
            endcase
            if (ph == 0)
            begin
                // On a one-page pool every request above a page is refused.
                send_command(CMD_ALLOC, 15'd2, '0);
                send_command(CMD_ALLOC, 15'd1, '0);
                send_command(CMD_ALLOC, 15'd1, '0);
                send_command(CMD_FREE, '0, 32'hffff_0001);
                send_command(CMD_FREE, '0, 32'hffff_0000);
            end
            repeat (per_phase) random_command();
        end

        drain();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
